// File: sv/psp_pkg.sv
`default_nettype none
package psp_pkg;

	localparam int HALF_LINES_DEF = 120;
	localparam int DIV_W = 32;
	localparam logic [31:0] FLOOR_LIFT = 32'h0100_0000;
	localparam logic [31:0] ROOF_DROP = 32'h0060_0000;
	localparam logic [63:0] PI_Q62 = 64'hC90F_DAA2_2168_C235;
	localparam logic [63:0] PI_STEP = PI_Q62 / 512;

	typedef enum logic [1:0] {
		OP_PLAY  = 2'd0,
		OP_FLOOR = 2'd1,
		OP_ROOF  = 2'd2,
		OP_SPARE = 2'd3
	} op_t;

	typedef logic [10:0] qsine_t [257];

	// payload that rides alongside the divider
	typedef struct packed {
		op_t              op;
		logic signed [7:0] line;
		logic signed [9:0] sn;
		logic signed [9:0] cs;
		logic signed [9:0] sn2;
		logic signed [9:0] cs2;
		logic [31:0]       cam_x;
		logic [31:0]       cam_y;
		logic              neg;
	} side_t;

	function automatic logic [63:0] mulq62(logic [63:0] a, logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[125:62];
	endfunction

	// taylor series in q62, elaboration only
	function automatic logic [10:0] quarter_sine(int q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] prod;
		if (q == 0) return 11'd0;
		if (q >= 256) return 11'd1024;
		x = PI_STEP * 64'(q);
		x2 = mulq62(x, x);
		term = x;
		sum = x;
		for (int k = 1; k <= 12; k++) begin
			prod = mulq62(term, x2);
			case (k)
				1: term = prod / 6;
				2: term = prod / 20;
				3: term = prod / 42;
				4: term = prod / 72;
				5: term = prod / 110;
				6: term = prod / 156;
				7: term = prod / 210;
				8: term = prod / 272;
				9: term = prod / 342;
				10: term = prod / 420;
				11: term = prod / 506;
				default: term = prod / 600;
			endcase
			if (k % 2 == 1) sum = sum - term;
			else sum = sum + term;
		end
		return sum[62:52];
	endfunction

	function automatic qsine_t build_qsine();
		qsine_t t;
		for (int i = 0; i < 257; i++) t[i] = quarter_sine(i);
		return t;
	endfunction

	localparam qsine_t QSINE = build_qsine();

	// sine scaled by 1024, then shifted right by two
	function automatic logic signed [9:0] trig4(logic [9:0] a);
		logic [10:0]        v;
		logic signed [11:0] s;
		logic [8:0]         idx;
		if (a[8]) idx = 9'd256 - {1'b0, a[7:0]};
		else idx = {1'b0, a[7:0]};
		v = QSINE[idx];
		s = a[9] ? -$signed({1'b0, v}) : $signed({1'b0, v});
		return 10'(s >>> 2);
	endfunction

endpackage
`default_nettype wire

// File: sv/perspective_scanline_projection.sv
`default_nettype none
// channel   direction  handshake                       payload
// command   in         start & !busy                   op line_offset yaw/pitch height cam
// result    out        done, one cycle, no back-off    step_x/y start_x/y palette_band
// config    in         apb write, psel&penable&pwrite  center_x, written at any address, read at address 0
//
// one line enters every cycle; busy is never raised
// each result is registered through stages 1 to 3, then the 32-stage one-bit-per-stage divider,
// then stages 4 to 8: eight register stages besides the divider
// reset clears the valid bits and sets center_x to 212
module perspective_scanline_projection #(
	parameter int HALF_LINES = psp_pkg::HALF_LINES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         start,
	output logic              busy,
	input  wire logic [1:0]   op,
	input  wire logic [7:0]   line_offset,
	input  wire logic [9:0]   yaw_angle,
	input  wire logic [9:0]   pitch_angle,
	input  wire logic [31:0]  camera_height,
	input  wire logic [31:0]  cam_x,
	input  wire logic [31:0]  cam_y,
	output logic              done,
	output logic [31:0]       step_x,
	output logic [31:0]       step_y,
	output logic [31:0]       start_x,
	output logic [31:0]       start_y,
	output logic [2:0]        palette_band,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [1:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import psp_pkg::*;

	localparam int SIDE_W = $bits(side_t);
	localparam logic signed [10:0] LINE_LO = 11'(-HALF_LINES);
	localparam logic signed [10:0] LINE_HI = 11'(HALF_LINES - 1);

	logic [9:0] center_q;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign prdata = (paddr == 2'd0) ? {22'd0, center_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) center_q <= 10'd212;
		else if (psel && penable && pwrite && pready) center_q <= pwdata[9:0];
	end

	function automatic logic [31:0] sx10(logic signed [9:0] v);
		return {{22{v[9]}}, v};
	endfunction

	function automatic logic [31:0] asr8(logic [31:0] v);
		return 32'($signed(v) >>> 8);
	endfunction

	// stage 1: clamp, trig lookup, numerator
	logic signed [10:0] line_w;
	logic signed [7:0]  line_c;
	logic [9:0]         npitch;
	logic [31:0]        num_c;
	op_t                op_c;

	assign op_c = op_t'(op);
	assign line_w = {{3{line_offset[7]}}, line_offset};
	assign npitch = 10'd0 - pitch_angle;

	always_comb begin
		if (line_w < LINE_LO) line_c = LINE_LO[7:0];
		else if (line_w > LINE_HI) line_c = LINE_HI[7:0];
		else line_c = line_offset;
		case (op_c)
			OP_FLOOR: num_c = camera_height + FLOOR_LIFT;
			OP_ROOF: num_c = 32'($signed(camera_height) >>> 2) - ROOF_DROP;
			default: num_c = camera_height;
		endcase
	end

	logic        vld_s1;
	side_t       side_s1;
	logic [31:0] num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else vld_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		side_s1.op <= op_c;
		side_s1.line <= line_c;
		side_s1.sn <= trig4(yaw_angle);
		side_s1.cs <= trig4(yaw_angle + 10'd256);
		side_s1.sn2 <= trig4(npitch);
		side_s1.cs2 <= trig4(npitch + 10'd256);
		side_s1.cam_x <= (op_c == OP_ROOF) ? 32'($signed(cam_x) >>> 3) : cam_x;
		side_s1.cam_y <= (op_c == OP_ROOF) ? 32'($signed(cam_y) >>> 3) : cam_y;
		side_s1.neg <= 1'b0;
		num_s1 <= num_c;
	end

	// stage 2: divisor
	logic [31:0] lc_c;
	logic [31:0] dv_c;
	assign lc_c = {{24{side_s1.line[7]}}, side_s1.line} * sx10(side_s1.cs2);
	assign dv_c = sx10(side_s1.sn2) + asr8(lc_c);

	logic        vld_s2;
	side_t       side_s2;
	logic [31:0] num_s2;
	logic [31:0] dv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		num_s2 <= num_s1;
		dv_s2 <= (dv_c == 32'd0) ? 32'd1 : dv_c;
	end

	// stage 3: magnitudes into the divider
	logic        vld_s3;
	side_t       side_c;
	side_t       side_s3;
	logic [31:0] mn_s3;
	logic [31:0] md_s3;

	always_comb begin
		side_c = side_s2;
		side_c.neg = num_s2[31] ^ dv_s2[31];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_c;
		mn_s3 <= num_s2[31] ? 32'd0 - num_s2 : num_s2;
		md_s3 <= dv_s2[31] ? 32'd0 - dv_s2 : dv_s2;
	end

	logic        div_vld;
	logic [31:0] div_q;
	side_t       div_side;

	psp_div #(
		.SIDE_W(SIDE_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s3),
		.num(mn_s3),
		.den(md_s3),
		.in_side(side_s3),
		.out_valid(div_vld),
		.quo(div_q),
		.out_side(div_side)
	);

	// stage 4: signed quotient
	logic        vld_s4;
	side_t       side_s4;
	logic [31:0] h_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= div_vld;
	end

	always_ff @(posedge clk) begin
		side_s4 <= div_side;
		h_s4 <= div_side.neg ? 32'd0 - div_q : div_q;
	end

	// stage 5: steps and first products
	logic        vld_s5;
	side_t       side_s5;
	logic [31:0] dx_s5;
	logic [31:0] dy_s5;
	logic [31:0] a_s5;
	logic [31:0] lh_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s5 <= 1'b0;
		else vld_s5 <= vld_s4;
	end

	always_ff @(posedge clk) begin
		side_s5 <= side_s4;
		dx_s5 <= asr8((32'd0 - sx10(side_s4.cs)) * h_s4);
		dy_s5 <= asr8(sx10(side_s4.sn) * h_s4);
		a_s5 <= asr8(sx10(side_s4.cs2) * h_s4);
		lh_s5 <= asr8({{24{side_s4.line[7]}}, side_s4.line} * h_s4);
	end

	// stage 6: line position
	logic        vld_s6;
	side_t       side_s6;
	logic [31:0] dx_s6;
	logic [31:0] dy_s6;
	logic [31:0] pos_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s6 <= 1'b0;
		else vld_s6 <= vld_s5;
	end

	always_ff @(posedge clk) begin
		side_s6 <= side_s5;
		dx_s6 <= dx_s5;
		dy_s6 <= dy_s5;
		pos_s6 <= a_s5 - asr8(sx10(side_s5.sn2) * lh_s5);
	end

	// stage 7: band and start products
	logic [31:0] mag_c;
	logic [17:0] b15_c;
	logic [17:0] braw_c;
	logic [2:0]  band_c;

	assign mag_c = pos_s6[31] ? 32'd0 - pos_s6 : pos_s6;
	assign b15_c = {1'b0, mag_c[31:15]};

	always_comb begin
		case (side_s6.op)
			OP_ROOF: braw_c = mag_c[31:14];
			OP_FLOOR: braw_c = (b15_c < 18'd8) ? 18'd0 : b15_c - 18'd8;
			default: braw_c = b15_c;
		endcase
		band_c = (braw_c > 18'd7) ? 3'd7 : braw_c[2:0];
	end

	logic        vld_s7;
	side_t       side_s7;
	logic [31:0] dx_s7;
	logic [31:0] dy_s7;
	logic [31:0] p1_s7;
	logic [31:0] p2_s7;
	logic [31:0] p3_s7;
	logic [31:0] p4_s7;
	logic [2:0]  band_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s7 <= 1'b0;
		else vld_s7 <= vld_s6;
	end

	always_ff @(posedge clk) begin
		side_s7 <= side_s6;
		dx_s7 <= dx_s6;
		dy_s7 <= dy_s6;
		p1_s7 <= sx10(side_s6.sn) * pos_s6;
		p2_s7 <= {22'd0, center_q} * dx_s6;
		p3_s7 <= sx10(side_s6.cs) * pos_s6;
		p4_s7 <= {22'd0, center_q} * dy_s6;
		band_s7 <= band_c;
	end

	// stage 8: result beat
	logic        vld_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s8 <= 1'b0;
		else vld_s8 <= vld_s7;
	end

	always_ff @(posedge clk) begin
		step_x <= dx_s7;
		step_y <= dy_s7;
		start_x <= p1_s7 - p2_s7 + side_s7.cam_x;
		start_y <= p3_s7 - p4_s7 + side_s7.cam_y;
		palette_band <= band_s7;
	end

	assign done = vld_s8;
endmodule
`default_nettype wire

// File: sv/psp_div.sv
`default_nettype none
module psp_div #(
	parameter int SIDE_W = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic [31:0]          num,
	input  wire logic [31:0]          den,
	input  wire logic [SIDE_W-1:0]    in_side,
	output logic                      out_valid,
	output logic [31:0]               quo,
	output logic [SIDE_W-1:0]         out_side
);
	import psp_pkg::*;

	logic              vld_s  [DIV_W+1];
	logic [DIV_W-1:0]  rem_s  [DIV_W+1];
	logic [DIV_W-1:0]  nq_s   [DIV_W+1];
	logic [DIV_W-1:0]  den_s  [DIV_W+1];
	logic [SIDE_W-1:0] side_s [DIV_W+1];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign nq_s[0] = num;
	assign den_s[0] = den;
	assign side_s[0] = in_side;

	for (genvar i = 0; i < DIV_W; i++) begin : g_stage
		logic [DIV_W:0]   sh;
		logic             ge;
		logic [DIV_W:0]   diff;
		assign sh = {rem_s[i], nq_s[i][DIV_W-1]};
		assign ge = sh >= {1'b0, den_s[i]};
		assign diff = sh - {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else vld_s[i+1] <= vld_s[i];
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? diff[DIV_W-1:0] : sh[DIV_W-1:0];
			nq_s[i+1] <= {nq_s[i][DIV_W-2:0], ge};
			den_s[i+1] <= den_s[i];
			side_s[i+1] <= side_s[i];
		end
	end

	assign out_valid = vld_s[DIV_W];
	assign quo = nq_s[DIV_W];
	assign out_side = side_s[DIV_W];
endmodule
`default_nettype wire
